FILE: hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants for the sparse triple transpose block.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_ENTRIES_DEF = 63;
   localparam int MAX_COLS_DEF    = 16;

   // Field widths fixed by the word formats.
   localparam int ROW_W      = 4;
   localparam int COL_W      = 4;
   localparam int VALUE_W    = 32;
   localparam int DIM_W      = 5;
   localparam int CNT_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_COLS = 2'd1;

   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   // One stored triple, kept in source orientation.
   typedef struct packed {
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD_WB,
      S_PREFIX,
      S_SCATTER,
      S_HDR,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/stt_if.sv
// ----------------------------------------------------------------------------
// stt channel interfaces
// Valid/ready channels for input triples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface stt_req_if import stt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [ROW_W-1:0]          in_row;
   logic [COL_W-1:0]          in_col;
   logic signed [VALUE_W-1:0] in_value;
   logic                      carries_entry;
   logic                      closes_set;

   modport source (output valid, output in_row, output in_col, output in_value,
                   output carries_entry, output closes_set, input ready);
   modport sink   (input valid, input in_row, input in_col, input in_value,
                   input carries_entry, input closes_set, output ready);
endinterface

interface stt_rsp_if import stt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      is_header;
   logic [DIM_W-1:0]          out_row;
   logic [DIM_W-1:0]          out_col;
   logic signed [VALUE_W-1:0] out_value;
   logic                      overflow;
   logic                      last;

   modport source (output valid, output is_header, output out_row, output out_col,
                   output out_value, output overflow, output last, input ready);
   modport sink   (input valid, input is_header, input out_row, input out_col,
                   input out_value, input overflow, input last, output ready);
endinterface

interface stt_csr_if import stt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/sparse_triple_transpose.sv
// ----------------------------------------------------------------------------
// sparse_triple_transpose
// Fast transpose of a sparse matrix in triple form, by column counts.
// ----------------------------------------------------------------------------
//   channel   dir   word contents
//   req_bus   in    in_row, in_col, in_value, carries_entry, closes_set
//   rsp_bus   out   is_header, out_row, out_col, out_value, overflow, last
//   csr_bus   in    index, data (register write, always ready)
//
// A triple is a read-modify-write of the column count memory: read in S_IDLE,
// written back in S_LOAD_WB. A closing word starts the prefix pass, then the
// scatter through the position memory, then n+1 results at up to one per
// cycle. After reset a clearing pass zeroes the count memory before any word
// is taken. A stalled rsp_bus holds the result register; req_bus is taken
// again once the last result of the run is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_triple_transpose import stt_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int MAX_COLS    = MAX_COLS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   stt_req_if.sink    req_bus,
   stt_rsp_if.source  rsp_bus,
   stt_csr_if.sink    csr_bus
);

   localparam int CIDX_W = $clog2(MAX_COLS);
   localparam int PF_W   = $clog2(MAX_COLS + 1);
   localparam int EW     = $clog2(MAX_ENTRIES + 1);
   localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   localparam logic [PF_W-1:0]   PF_END   = PF_W'(MAX_COLS);
   localparam logic [CIDX_W-1:0] CIDX_TOP = CIDX_W'(MAX_COLS - 1);
   localparam logic [EW-1:0]     ENT_FULL = EW'(MAX_ENTRIES);
   localparam logic [6:0]        COLS_LIM = 7'(MAX_COLS);

   typedef struct packed {
      logic                      is_header;
      logic [DIM_W-1:0]          out_row;
      logic [DIM_W-1:0]          out_col;
      logic signed [VALUE_W-1:0] out_value;
      logic                      overflow;
      logic                      last;
   } rsp_type;

   // Memories.
   logic [CNT_W-1:0] cnt_mem [MAX_COLS];
   logic [CNT_W-1:0] pos_mem [MAX_COLS];
   entry_type        ld_mem  [MAX_ENTRIES];
   entry_type        srt_mem [MAX_ENTRIES];

   logic              cnt_re, cnt_we;
   logic [CIDX_W-1:0] cnt_rd_addr, cnt_wr_addr;
   logic [CNT_W-1:0]  cnt_wr_data, cnt_rd_ff;
   logic              pos_re, pos_we;
   logic [CIDX_W-1:0] pos_rd_addr, pos_wr_addr;
   logic [CNT_W-1:0]  pos_wr_data, pos_rd_ff;
   logic              ld_re, ld_we;
   logic [AW-1:0]     ld_rd_addr, ld_wr_addr;
   entry_type         ld_wr_data, ld_rd_ff;
   logic              srt_re, srt_we;
   logic [AW-1:0]     srt_rd_addr, srt_wr_addr;
   entry_type         srt_wr_data, srt_rd_ff;

   // Control and datapath registers.
   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [EW-1:0]     ent_cnt_ff, ent_cnt_in;
   logic              drop_ff, drop_in;
   logic [CIDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic [CIDX_W-1:0] ld_col_ff, ld_col_in;
   logic              close_ff, close_in;
   logic [PF_W-1:0]   pf_idx_ff, pf_idx_in;
   logic              pf_vld_ff, pf_vld_in;
   logic [CIDX_W-1:0] pf_col_ff, pf_col_in;
   logic [CNT_W-1:0]  acc_ff, acc_in;
   logic [EW-1:0]     sc_idx_ff, sc_idx_in;
   logic              s1_vld_ff, s1_vld_in;
   logic              s2_vld_ff, s2_vld_in;
   entry_type         s2_ent_ff, s2_ent_in;
   logic              fwd_vld_ff, fwd_vld_in;
   logic [CIDX_W-1:0] fwd_col_ff, fwd_col_in;
   logic [CNT_W-1:0]  fwd_pos_ff, fwd_pos_in;
   logic [EW-1:0]     em_idx_ff, em_idx_in;
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              col_ok, rsp_free, go_prefix, finish;
   logic [CIDX_W-1:0] s2_col;
   logic [CNT_W-1:0]  sc_pos;

   assign req_bus.ready     = (state_ff == S_IDLE);
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_vld_ff;
   assign rsp_bus.is_header = rsp_data_ff.is_header;
   assign rsp_bus.out_row   = rsp_data_ff.out_row;
   assign rsp_bus.out_col   = rsp_data_ff.out_col;
   assign rsp_bus.out_value = rsp_data_ff.out_value;
   assign rsp_bus.overflow  = rsp_data_ff.overflow;
   assign rsp_bus.last      = rsp_data_ff.last;

   assign col_ok   = 7'(req_bus.in_col) < COLS_LIM;
   assign rsp_free = !rsp_vld_ff || rsp_bus.ready;
   assign s2_col   = CIDX_W'(s2_ent_ff.col);

   // The previous scatter step writes the position memory at the same edge
   // this step reads it, so a repeated column takes the forwarded value.
   assign sc_pos = (fwd_vld_ff && (fwd_col_ff == s2_col)) ? fwd_pos_ff : pos_rd_ff;

   always_comb begin
      state_in    = state_ff;
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      ent_cnt_in  = ent_cnt_ff;
      drop_in     = drop_ff;
      clr_idx_in  = clr_idx_ff;
      ld_col_in   = ld_col_ff;
      close_in    = close_ff;
      pf_idx_in   = pf_idx_ff;
      pf_vld_in   = 1'b0;
      pf_col_in   = pf_col_ff;
      acc_in      = acc_ff;
      sc_idx_in   = sc_idx_ff;
      s1_vld_in   = 1'b0;
      s2_vld_in   = 1'b0;
      s2_ent_in   = s2_ent_ff;
      fwd_vld_in  = 1'b0;
      fwd_col_in  = fwd_col_ff;
      fwd_pos_in  = fwd_pos_ff;
      em_idx_in   = em_idx_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_bus.ready;
      rsp_data_in = rsp_data_ff;
      go_prefix   = 1'b0;
      finish      = 1'b0;

      cnt_re      = 1'b0;
      cnt_we      = 1'b0;
      cnt_rd_addr = '0;
      cnt_wr_addr = '0;
      cnt_wr_data = '0;
      pos_re      = 1'b0;
      pos_we      = 1'b0;
      pos_rd_addr = '0;
      pos_wr_addr = '0;
      pos_wr_data = '0;
      ld_re       = 1'b0;
      ld_we       = 1'b0;
      ld_rd_addr  = '0;
      ld_wr_addr  = '0;
      ld_wr_data  = '0;
      srt_re      = 1'b0;
      srt_we      = 1'b0;
      srt_rd_addr = '0;
      srt_wr_addr = '0;
      srt_wr_data = '0;

      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_MATRIX_ROWS: rows_in = csr_bus.data;
            REG_MATRIX_COLS: cols_in = csr_bus.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            cnt_we      = 1'b1;
            cnt_wr_addr = clr_idx_ff;
            clr_idx_in  = clr_idx_ff + 1'b1;
            if (clr_idx_ff == CIDX_TOP) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.carries_entry && col_ok && (ent_cnt_ff < ENT_FULL)) begin
                  ld_we       = 1'b1;
                  ld_wr_addr  = AW'(ent_cnt_ff);
                  ld_wr_data  = '{row: req_bus.in_row, col: req_bus.in_col,
                                  value: req_bus.in_value};
                  ent_cnt_in  = ent_cnt_ff + 1'b1;
                  cnt_re      = 1'b1;
                  cnt_rd_addr = CIDX_W'(req_bus.in_col);
                  ld_col_in   = CIDX_W'(req_bus.in_col);
                  close_in    = req_bus.closes_set;
                  state_in    = S_LOAD_WB;
               end else begin
                  if (req_bus.carries_entry && col_ok) begin
                     drop_in = 1'b1;
                  end
                  go_prefix = req_bus.closes_set;
               end
            end
         end
         S_LOAD_WB: begin
            cnt_we      = 1'b1;
            cnt_wr_addr = ld_col_ff;
            cnt_wr_data = cnt_rd_ff + 1'b1;
            if (close_ff) begin
               go_prefix = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PREFIX: begin
            if (pf_idx_ff != PF_END) begin
               cnt_re      = 1'b1;
               cnt_rd_addr = CIDX_W'(pf_idx_ff);
               pf_col_in   = CIDX_W'(pf_idx_ff);
               pf_idx_in   = pf_idx_ff + 1'b1;
               pf_vld_in   = 1'b1;
            end
            // Store the start position and clear the count for the next set.
            if (pf_vld_ff) begin
               pos_we      = 1'b1;
               pos_wr_addr = pf_col_ff;
               pos_wr_data = acc_ff;
               cnt_we      = 1'b1;
               cnt_wr_addr = pf_col_ff;
               acc_in      = acc_ff + cnt_rd_ff;
            end
            if ((pf_idx_ff == PF_END) && !pf_vld_ff) begin
               sc_idx_in = '0;
               state_in  = S_SCATTER;
            end
         end
         S_SCATTER: begin
            if (sc_idx_ff != ent_cnt_ff) begin
               ld_re      = 1'b1;
               ld_rd_addr = AW'(sc_idx_ff);
               sc_idx_in  = sc_idx_ff + 1'b1;
               s1_vld_in  = 1'b1;
            end
            if (s1_vld_ff) begin
               pos_re      = 1'b1;
               pos_rd_addr = CIDX_W'(ld_rd_ff.col);
               s2_ent_in   = ld_rd_ff;
               s2_vld_in   = 1'b1;
            end
            if (s2_vld_ff) begin
               srt_we      = 1'b1;
               srt_wr_addr = AW'(sc_pos);
               srt_wr_data = s2_ent_ff;
               pos_we      = 1'b1;
               pos_wr_addr = s2_col;
               pos_wr_data = sc_pos + 1'b1;
               fwd_vld_in  = 1'b1;
               fwd_col_in  = s2_col;
               fwd_pos_in  = sc_pos + 1'b1;
            end
            if ((sc_idx_ff == ent_cnt_ff) && !s1_vld_ff && !s2_vld_ff) begin
               state_in = S_HDR;
            end
         end
         S_HDR: begin
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = '{is_header: 1'b1, out_row: cols_ff, out_col: rows_ff,
                               out_value: VALUE_W'(ent_cnt_ff), overflow: drop_ff,
                               last: (ent_cnt_ff == '0)};
               if (ent_cnt_ff == '0) begin
                  finish = 1'b1;
               end else begin
                  srt_re      = 1'b1;
                  srt_rd_addr = '0;
                  em_idx_in   = EW'(1);
                  state_in    = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = '{is_header: 1'b0, out_row: DIM_W'(srt_rd_ff.col),
                               out_col: DIM_W'(srt_rd_ff.row), out_value: srt_rd_ff.value,
                               overflow: 1'b0, last: (em_idx_ff == ent_cnt_ff)};
               if (em_idx_ff == ent_cnt_ff) begin
                  finish = 1'b1;
               end else begin
                  srt_re      = 1'b1;
                  srt_rd_addr = AW'(em_idx_ff);
                  em_idx_in   = em_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (go_prefix) begin
         pf_idx_in = '0;
         acc_in    = '0;
         state_in  = S_PREFIX;
      end
      if (finish) begin
         ent_cnt_in = '0;
         drop_in    = 1'b0;
         state_in   = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         rows_ff    <= DIM_RESET;
         cols_ff    <= DIM_RESET;
         ent_cnt_ff <= '0;
         drop_ff    <= 1'b0;
         clr_idx_ff <= '0;
         pf_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rows_ff    <= rows_in;
         cols_ff    <= cols_in;
         ent_cnt_ff <= ent_cnt_in;
         drop_ff    <= drop_in;
         clr_idx_ff <= clr_idx_in;
         pf_vld_ff  <= pf_vld_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         fwd_vld_ff <= fwd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_col_ff   <= ld_col_in;
      close_ff    <= close_in;
      pf_idx_ff   <= pf_idx_in;
      pf_col_ff   <= pf_col_in;
      acc_ff      <= acc_in;
      sc_idx_ff   <= sc_idx_in;
      s2_ent_ff   <= s2_ent_in;
      fwd_col_ff  <= fwd_col_in;
      fwd_pos_ff  <= fwd_pos_in;
      em_idx_ff   <= em_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_wr_addr] <= pos_wr_data;
      end
      if (pos_re) begin
         pos_rd_ff <= pos_mem[pos_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         ld_mem[ld_wr_addr] <= ld_wr_data;
      end
      if (ld_re) begin
         ld_rd_ff <= ld_mem[ld_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (srt_we) begin
         srt_mem[srt_wr_addr] <= srt_wr_data;
      end
      if (srt_re) begin
         srt_rd_ff <= srt_mem[srt_rd_addr];
      end
   end

   // Checks.
   a_ent_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      ent_cnt_ff <= ENT_FULL)
      else $error("entry count passed the store capacity");

   a_prefix_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREFIX && pf_idx_ff == PF_END && !pf_vld_ff)
         |-> acc_ff == CNT_W'(ent_cnt_ff))
      else $error("column counts do not add up to the entry count");

   a_scatter_slot: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> 7'(sc_pos) < 7'(ent_cnt_ff))
      else $error("scatter position beyond the loaded entries");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !(pf_vld_ff || s1_vld_ff || s2_vld_ff))
      else $error("input taken while a pass is still in flight");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sparse triple transpose block. Matrices are loaded as bursts
// of triples, and each closing word must produce a header and then the
// triples in column-major order. Every result word is compared with a
// transpose predictor kept in the testbench. The sender idles in bursts and
// the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module testbench;
   import stt_pkg::*;

   localparam int ENTRY_CAPACITY = MAX_ENTRIES_DEF;
   localparam int COLUMN_SLOTS   = MAX_COLS_DEF;
   localparam int IDLE_PAUSE     = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_WORDS   = 480;
   localparam int REPORT_LIMIT   = 10;

   // Index 2 has no register behind it; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 2'd2;

   localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

   typedef struct {
      entry_type triple;
      logic      carries_entry;
      logic      closes_set;
   } source_word_type;

   typedef struct {
      logic               is_header;
      logic [DIM_W-1:0]   out_row;
      logic [DIM_W-1:0]   out_col;
      logic [VALUE_W-1:0] out_value;
      logic               overflow;
      logic               last;
   } transposed_word_type;

   logic clock;
   logic reset;

   stt_req_if req_bus ();
   stt_rsp_if rsp_bus ();
   stt_csr_if csr_bus ();

   sparse_triple_transpose DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predictor copy of the block state.
   logic [DIM_W-1:0] rows_setting;
   logic [DIM_W-1:0] cols_setting;
   logic [CNT_W-1:0] column_tally [COLUMN_SLOTS];
   entry_type        arrival_order [ENTRY_CAPACITY];
   int               stored_count;
   logic             store_overflowed;

   source_word_type     source_words [$];
   transposed_word_type transposed_words [$];

   int          words_queued;
   int          words_taken;
   int          fail_count;
   int          quiet_cycles;
   logic        req_fire;
   int          burst_left;
   int          gap_left;
   logic [15:0] ready_pattern;
   int          pattern_age;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Loads one word into the predictor and, on a closing word, queues the
   // header and the transposed triples in the order the block must emit them.
   function automatic void transpose_word(source_word_type w);
      logic [CNT_W-1:0]    start_at [COLUMN_SLOTS];
      logic [CNT_W-1:0]    running;
      entry_type           column_major [ENTRY_CAPACITY];
      transposed_word_type res;
      int                  slot;
      if (w.carries_entry) begin
         if (stored_count < ENTRY_CAPACITY) begin
            arrival_order[stored_count] = w.triple;
            stored_count++;
            column_tally[w.triple.col] = column_tally[w.triple.col] + 1'b1;
         end else begin
            store_overflowed = 1'b1;
         end
      end
      if (!w.closes_set) return;
      running = '0;
      for (int c = 0; c < COLUMN_SLOTS; c++) begin
         start_at[c] = running;
         running = running + column_tally[c];
      end
      // Scanning in arrival order keeps entries of one column stable.
      for (int i = 0; i < stored_count; i++) begin
         slot = start_at[arrival_order[i].col];
         start_at[arrival_order[i].col] = start_at[arrival_order[i].col] + 1'b1;
         column_major[slot] = arrival_order[i];
      end
      res = '{1'b1, cols_setting, rows_setting, VALUE_W'(stored_count),
              store_overflowed, stored_count == 0};
      transposed_words.push_back(res);
      for (int i = 0; i < stored_count; i++) begin
         res = '{1'b0, DIM_W'(column_major[i].col), DIM_W'(column_major[i].row),
                 column_major[i].value, 1'b0, i + 1 == stored_count};
         transposed_words.push_back(res);
      end
      foreach (column_tally[c]) column_tally[c] = '0;
      stored_count = 0;
      store_overflowed = 1'b0;
   endfunction

   // Monitor: predicts on accepted words, checks result words, watches for hangs.
   always @(posedge clock) begin
      source_word_type     taken;
      transposed_word_type want;
      logic                rsp_fire;
      logic                csr_fire;
      if (reset) begin
         rows_setting = DIM_RESET;
         cols_setting = DIM_RESET;
         foreach (column_tally[c]) column_tally[c] = '0;
         stored_count = 0;
         store_overflowed = 1'b0;
         req_fire = 1'b0;
         words_taken = 0;
         quiet_cycles = 0;
      end else begin
         req_fire = req_bus.valid && req_bus.ready;
         rsp_fire = rsp_bus.valid && rsp_bus.ready;
         csr_fire = csr_bus.valid && csr_bus.ready;
         if (csr_fire) begin
            case (csr_bus.index)
               REG_MATRIX_ROWS: rows_setting = csr_bus.data;
               REG_MATRIX_COLS: cols_setting = csr_bus.data;
               default: ;
            endcase
         end
         if (req_fire) begin
            taken.triple = '{row: req_bus.in_row, col: req_bus.in_col,
                             value: req_bus.in_value};
            taken.carries_entry = req_bus.carries_entry;
            taken.closes_set = req_bus.closes_set;
            transpose_word(taken);
            words_taken++;
         end
         if (rsp_fire) begin
            if (transposed_words.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("tb: result word with none expected: hdr=%0b row=%0d col=%0d",
                           rsp_bus.is_header, rsp_bus.out_row, rsp_bus.out_col);
            end else begin
               want = transposed_words.pop_front();
               if (rsp_bus.is_header !== want.is_header || rsp_bus.out_row !== want.out_row ||
                   rsp_bus.out_col !== want.out_col || rsp_bus.out_value !== want.out_value ||
                   rsp_bus.overflow !== want.overflow || rsp_bus.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("tb: mismatch expected hdr=%0b row=%0d col=%0d val=%h ovf=%0b last=%0b",
                              want.is_header, want.out_row, want.out_col, want.out_value,
                              want.overflow, want.last);
                     $display("tb:               got hdr=%0b row=%0d col=%0d val=%h ovf=%0b last=%0b",
                              rsp_bus.is_header, rsp_bus.out_row, rsp_bus.out_col,
                              rsp_bus.out_value, rsp_bus.overflow, rsp_bus.last);
                  end
               end
            end
         end
         if (req_fire || rsp_fire || csr_fire) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Driver: sends words in bursts and stalls the result channel on a pattern.
   always @(negedge clock) begin
      source_word_type next_word;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (source_words.size() > 0) begin
               next_word = source_words.pop_front();
               req_bus.in_row        <= next_word.triple.row;
               req_bus.in_col        <= next_word.triple.col;
               req_bus.in_value      <= next_word.triple.value;
               req_bus.carries_entry <= next_word.carries_entry;
               req_bus.closes_set    <= next_word.closes_set;
               req_bus.valid         <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         // A new stall pattern whenever pattern_age runs out; a quarter of them never stall.
         if (pattern_age == 0) begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
            pattern_age = 64;
         end
         pattern_age--;
         rsp_bus.ready <= ready_pattern[0];
         ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
   end

   function automatic void add_word(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                    logic [VALUE_W-1:0] value, logic carries,
                                    logic closes);
      source_word_type w;
      w.triple = '{row: row, col: col, value: value};
      w.carries_entry = carries;
      w.closes_set = closes;
      source_words.push_back(w);
      words_queued++;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 31))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      if ($urandom_range(0, 5) == 0) return DIM_W'($urandom_range(0, 31));
      return DIM_W'($urandom_range(1, 16));
   endfunction

   // Queues one matrix with random content; returns the number of words
   // queued for it, ignored filler words included.
   function automatic int queue_random_set(int entries);
      int   words;
      int   col_span;
      int   col_base;
      logic closing_triple;
      words = 0;
      // Narrow column ranges pile entries into few columns.
      col_span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : COLUMN_SLOTS;
      col_base = $urandom_range(0, COLUMN_SLOTS - col_span);
      closing_triple = (entries > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < entries; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_word(ROW_W'($urandom), COL_W'($urandom), $urandom, 1'b0, 1'b0);
            words++;
         end
         add_word(ROW_W'($urandom), COL_W'($urandom_range(col_base, col_base + col_span - 1)),
                  pick_value(), 1'b1, closing_triple && i == entries - 1);
         words++;
      end
      if (!closing_triple) begin
         add_word(ROW_W'($urandom), COL_W'($urandom), $urandom, 1'b0, 1'b1);
         words++;
      end
      return words;
   endfunction

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready)) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Waits until every word is taken and every result has come back, then
   // lets the block finish any trailing work.
   task automatic settle();
      @(negedge clock);
      while (words_taken != words_queued || transposed_words.size() != 0) @(negedge clock);
      repeat (IDLE_PAUSE) @(negedge clock);
   endtask

   initial begin
      int random_words;
      int set_entries;
      words_queued = 0;
      words_taken = 0;
      fail_count = 0;
      burst_left = 0;
      gap_left = 0;
      pattern_age = 0;
      ready_pattern = '1;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_row = '0;
      req_bus.in_col = '0;
      req_bus.in_value = '0;
      req_bus.carries_entry = 1'b0;
      req_bus.closes_set = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_MATRIX_ROWS;
      csr_bus.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full-size matrix: empty set, value extremes, a bare word that does
      // nothing, several entries in one column, and a close that carries a triple.
      write_register(REG_MATRIX_ROWS, 5'd16);
      write_register(REG_MATRIX_COLS, 5'd16);
      add_word(4'd0, 4'd0, '0, 1'b0, 1'b1);
      add_word(4'd0, 4'd0, VALUE_MIN, 1'b1, 1'b0);
      add_word(4'd15, 4'd15, VALUE_MAX, 1'b1, 1'b0);
      add_word(4'd3, 4'd5, '1, 1'b1, 1'b0);
      add_word(4'd9, 4'd9, 32'h1234_5678, 1'b0, 1'b0);
      add_word(4'd7, 4'd5, '0, 1'b1, 1'b0);
      add_word(4'd2, 4'd5, 32'h0BAD_F00D, 1'b1, 1'b0);
      add_word(4'd15, 4'd0, 32'd1, 1'b1, 1'b0);
      add_word(4'd9, 4'd10, 32'hAAAA_AAAA, 1'b1, 1'b1);
      settle();

      // Smallest matrix with entries that lie outside the configured size.
      write_register(REG_MATRIX_ROWS, 5'd1);
      write_register(REG_MATRIX_COLS, 5'd1);
      add_word(4'd0, 4'd0, 32'd5, 1'b1, 1'b0);
      add_word(4'd12, 4'd9, 32'h5555_5555, 1'b1, 1'b0);
      add_word(4'd14, 4'd3, 32'hFFFF_FFF9, 1'b1, 1'b0);
      add_word(4'd15, 4'd15, '1, 1'b0, 1'b1);
      settle();

      // Out-of-range register values are echoed; an unmapped index is ignored.
      write_register(REG_MATRIX_ROWS, 5'd0);
      write_register(REG_MATRIX_COLS, 5'd31);
      write_register(REG_UNMAPPED, 5'd3);
      add_word(4'd6, 4'd6, 32'd42, 1'b1, 1'b1);
      add_word(4'd0, 4'd0, '0, 1'b0, 1'b1);
      settle();

      write_register(REG_MATRIX_ROWS, 5'd31);
      write_register(REG_MATRIX_COLS, 5'd0);
      add_word(4'd1, 4'd2, 32'd3, 1'b1, 1'b1);
      settle();

      // Random matrices, starting with one that overfills the entry store.
      write_register(REG_MATRIX_ROWS, pick_dim());
      write_register(REG_MATRIX_COLS, pick_dim());
      random_words = queue_random_set(ENTRY_CAPACITY + 3);
      while (random_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 3) == 0) begin
            settle();
            write_register(REG_MATRIX_ROWS, pick_dim());
            write_register(REG_MATRIX_COLS, pick_dim());
         end
         case ($urandom_range(0, 11))
            0:       set_entries = 0;
            1:       set_entries = $urandom_range(ENTRY_CAPACITY - 5, ENTRY_CAPACITY + 7);
            default: set_entries = $urandom_range(1, 20);
         endcase
         random_words += queue_random_set(set_entries);
      end
      settle();

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
